// ===== design/sce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_pkg
// Shared constants, codes and types of the speech capture endpointer.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int MAX_CAPACITY = 1048576;
  localparam int MAX_FRAME    = 4096;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 8;
  localparam int PROD_W   = 23;
  localparam int CNT_W    = 21;
  localparam int FRAME_W  = 13;
  localparam int ADDR_W   = 20;
  localparam int IDX_W    = 3;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 64;
  localparam int STEP_W   = 5;

  localparam int SAT_POS = 32767;
  localparam int SAT_NEG = 32768;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_ABORT  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_SILENCE_LEVEL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEAD_LIMIT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_TRAIL_LIMIT    = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_SPEECH     = 3'd3;
  localparam logic [IDX_W-1:0] REG_GAIN_NUM       = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN_DEN       = 3'd5;
  localparam logic [IDX_W-1:0] REG_FRAME_LENGTH   = 3'd6;
  localparam logic [IDX_W-1:0] REG_CAPACITY       = 3'd7;

  typedef enum logic [2:0] {
    REC_IDLE      = 3'd0,
    REC_ACTIVE    = 3'd1,
    REC_COMPLETED = 3'd2,
    REC_FAILED    = 3'd3,
    REC_ABORTED   = 3'd4
  } rec_t;

  typedef enum logic [2:0] {
    CAUSE_NONE  = 3'd0,
    CAUSE_TRAIL = 3'd1,
    CAUSE_FULL  = 3'd2,
    CAUSE_LEAD  = 3'd3,
    CAUSE_ABORT = 3'd4,
    CAUSE_EMPTY = 3'd5
  } cause_t;

  // Limits as seen by the capture tracker, frame length and capacity
  // already clamped to their legal range.
  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [CNT_W-1:0]    lead_limit;
    logic [CNT_W-1:0]    trail_limit;
    logic [CNT_W-1:0]    min_speech;
    logic [FRAME_W-1:0]  flen;
    logic [CNT_W-1:0]    cap;
  } cfg_t;

  typedef struct packed {
    logic                store_enable;
    logic [ADDR_W-1:0]   store_address;
    rec_t                rec_state;
    cause_t              stop_cause;
    logic [CNT_W-1:0]    stored_total;
  } track_out_t;

endpackage

// ===== design/speech_capture_endpointer.sv =====
`timescale 1ns / 1ps
// One beat is handled at a time: a sample beat passes through the serial gain unit and
// then the tracker, while start, abort and unused operations go to the tracker alone.
// The next beat is taken in the cycle after the result is loaded into the output
// register, and a result waits in the hold state while the output is stalled.
// Reset (rst, synchronous, active high) restores the register defaults and idles.
// ----------------------------------------------------------------------------
// speech_capture_endpointer
// Applies a fractional gain to microphone words and runs the capture endpoint
// decision that starts, completes or abandons a recording into a sample store.
// ----------------------------------------------------------------------------
module speech_capture_endpointer (
  input  logic                       clk,
  input  logic                       rst,
  // Input stream.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [sce_pkg::IN_W-1:0]   s_tdata,   // raw_word[31:0]
  input  logic [1:0]                 s_tuser,   // operation[1:0]
  // Result stream.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sce_pkg::OUT_W-1:0]  m_tdata,   // gained_sample[15:0], store_enable[16],
                                                // store_address[36:17], rec_state[39:37],
                                                // stop_cause[42:40], stored_total[63:43]
  // Configuration writes.
  input  logic                       cfg_we,
  input  logic [sce_pkg::IDX_W-1:0]  cfg_index,
  input  logic [sce_pkg::CNT_W-1:0]  cfg_data
);

  // The controller walks each beat through the gain unit (samples only) and then
  // the tracker. A finished result that cannot yet enter the output register,
  // because the previous one has not been taken, waits in the hold state; the
  // tracker and gain unit keep their outputs steady until the next beat starts.
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GAIN  = 4'b0010,
    S_TRACK = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t state;

  logic [sce_pkg::SAMPLE_W-1:0] silence_level;
  logic [sce_pkg::CNT_W-1:0]    lead_silence_limit;
  logic [sce_pkg::CNT_W-1:0]    trail_silence_limit;
  logic [sce_pkg::CNT_W-1:0]    min_speech_len;
  logic [sce_pkg::GAIN_W-1:0]   gain_numerator;
  logic [sce_pkg::GAIN_W-1:0]   gain_denominator;
  logic [sce_pkg::FRAME_W-1:0]  frame_length;
  logic [sce_pkg::CNT_W-1:0]    capacity;

  sce_pkg::cfg_t       cfg;
  sce_pkg::track_out_t track_res;

  logic                                accept;
  logic                                is_sample;
  logic                                gain_start;
  logic                                gain_done;
  logic signed [sce_pkg::SAMPLE_W-1:0] gained;
  logic [sce_pkg::SAMPLE_W-1:0]        gained_mag;
  logic                                track_go;
  logic [1:0]                          track_op;
  logic                                track_done;
  logic                                out_free;
  logic                                load;

  // Register file. The tracker sees frame length and capacity already clamped:
  // a zero frame length acts as one sample, and both are capped at their maxima.
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_level       <= sce_pkg::SAMPLE_W'(400);
      lead_silence_limit  <= sce_pkg::CNT_W'(96000);
      trail_silence_limit <= sce_pkg::CNT_W'(64000);
      min_speech_len      <= sce_pkg::CNT_W'(6400);
      gain_numerator      <= sce_pkg::GAIN_W'(5);
      gain_denominator    <= sce_pkg::GAIN_W'(2);
      frame_length        <= sce_pkg::FRAME_W'(512);
      capacity            <= sce_pkg::CNT_W'(960000);
    end else if (cfg_we) begin
      case (cfg_index)
        sce_pkg::REG_SILENCE_LEVEL: silence_level       <= cfg_data[sce_pkg::SAMPLE_W-1:0];
        sce_pkg::REG_LEAD_LIMIT:    lead_silence_limit  <= cfg_data;
        sce_pkg::REG_TRAIL_LIMIT:   trail_silence_limit <= cfg_data;
        sce_pkg::REG_MIN_SPEECH:    min_speech_len      <= cfg_data;
        sce_pkg::REG_GAIN_NUM:      gain_numerator      <= cfg_data[sce_pkg::GAIN_W-1:0];
        sce_pkg::REG_GAIN_DEN:      gain_denominator    <= cfg_data[sce_pkg::GAIN_W-1:0];
        sce_pkg::REG_FRAME_LENGTH:  frame_length        <= cfg_data[sce_pkg::FRAME_W-1:0];
        sce_pkg::REG_CAPACITY:      capacity            <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.level       = silence_level;
    cfg.lead_limit  = lead_silence_limit;
    cfg.trail_limit = trail_silence_limit;
    cfg.min_speech  = min_speech_len;
    if (frame_length == '0) begin
      cfg.flen = sce_pkg::FRAME_W'(1);
    end else if (frame_length > sce_pkg::FRAME_W'(sce_pkg::MAX_FRAME)) begin
      cfg.flen = sce_pkg::FRAME_W'(sce_pkg::MAX_FRAME);
    end else begin
      cfg.flen = frame_length;
    end
    cfg.cap = (capacity > sce_pkg::CNT_W'(sce_pkg::MAX_CAPACITY)) ?
              sce_pkg::CNT_W'(sce_pkg::MAX_CAPACITY) : capacity;
  end

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign gain_start = accept && (s_tuser == sce_pkg::OP_SAMPLE);
  assign track_go   = ((state == S_GAIN) && gain_done) ||
                      (accept && (s_tuser != sce_pkg::OP_SAMPLE));
  assign track_op   = (state == S_GAIN) ? sce_pkg::OP_SAMPLE : s_tuser;
  assign out_free   = !m_tvalid || m_tready;
  assign load       = (((state == S_TRACK) && track_done) || (state == S_HOLD)) && out_free;

  sce_gain u_gain (
    .clk    (clk),
    .rst    (rst),
    .start  (gain_start),
    .word   (s_tdata[sce_pkg::IN_W-1:sce_pkg::IN_W-sce_pkg::SAMPLE_W]),
    .num    (gain_numerator),
    .den    (gain_denominator),
    .done   (gain_done),
    .gained (gained),
    .mag    (gained_mag)
  );

  sce_track u_track (
    .clk    (clk),
    .rst    (rst),
    .go     (track_go),
    .op     (track_op),
    .mag    (gained_mag),
    .cfg    (cfg),
    .done   (track_done),
    .result (track_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_sample <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_sample <= (s_tuser == sce_pkg::OP_SAMPLE);
            state     <= (s_tuser == sce_pkg::OP_SAMPLE) ? S_GAIN : S_TRACK;
          end
        end
        S_GAIN: begin
          if (gain_done) begin
            state <= S_TRACK;
          end
        end
        S_TRACK: begin
          if (track_done) begin
            state <= out_free ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: non-sample beats report a zero sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {track_res.stored_total,
                  track_res.stop_cause,
                  track_res.rec_state,
                  track_res.store_address,
                  track_res.store_enable,
                  is_sample ? gained : sce_pkg::SAMPLE_W'(0)};
    end
  end

endmodule

// ===== design/sce_gain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_gain
// Bit-serial gain unit: shift-and-add multiply, restoring divide, saturate.
// ----------------------------------------------------------------------------
module sce_gain (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [sce_pkg::SAMPLE_W-1:0]        word,
  input  logic [sce_pkg::GAIN_W-1:0]          num,
  input  logic [sce_pkg::GAIN_W-1:0]          den,
  output logic                                done,
  output logic signed [sce_pkg::SAMPLE_W-1:0] gained,
  output logic [sce_pkg::SAMPLE_W-1:0]        mag
);

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_MUL  = 3'b010,
    G_DIV  = 3'b100
  } gstate_t;

  gstate_t                       state;
  logic                          neg;
  logic [sce_pkg::PROD_W-1:0]    mag_sh;
  logic [sce_pkg::GAIN_W-1:0]    num_sh;
  logic [sce_pkg::PROD_W-1:0]    acc;
  logic [sce_pkg::GAIN_W-1:0]    rem;
  logic [sce_pkg::GAIN_W-1:0]    den_r;
  logic [sce_pkg::STEP_W-1:0]    step;
  logic [sce_pkg::GAIN_W:0]      trial;
  logic                          fits;
  logic [sce_pkg::SAMPLE_W-1:0]  sat_mag;

  assign trial = {rem, acc[sce_pkg::PROD_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      done  <= 1'b0;
      step  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        G_IDLE: begin
          if (start) begin
            neg    <= word[sce_pkg::SAMPLE_W-1];
            mag_sh <= {{(sce_pkg::PROD_W-sce_pkg::SAMPLE_W){1'b0}},
                       word[sce_pkg::SAMPLE_W-1] ? sce_pkg::SAMPLE_W'(~word + 1'b1) : word};
            num_sh <= num;
            den_r  <= (den == '0) ? sce_pkg::GAIN_W'(1) : den;
            acc    <= '0;
            step   <= '0;
            state  <= G_MUL;
          end
        end
        G_MUL: begin
          if (num_sh[0]) begin
            acc <= acc + mag_sh;
          end
          mag_sh <= {mag_sh[sce_pkg::PROD_W-2:0], 1'b0};
          num_sh <= {1'b0, num_sh[sce_pkg::GAIN_W-1:1]};
          if (step == sce_pkg::STEP_W'(sce_pkg::GAIN_W - 1)) begin
            step  <= '0;
            rem   <= '0;
            state <= G_DIV;
          end else begin
            step <= step + 1'b1;
          end
        end
        G_DIV: begin
          // The quotient shifts in from the bottom as the dividend leaves the top.
          if (fits) begin
            rem <= sce_pkg::GAIN_W'(trial - {1'b0, den_r});
          end else begin
            rem <= trial[sce_pkg::GAIN_W-1:0];
          end
          acc <= {acc[sce_pkg::PROD_W-2:0], fits};
          if (step == sce_pkg::STEP_W'(sce_pkg::PROD_W - 1)) begin
            step  <= '0;
            done  <= 1'b1;
            state <= G_IDLE;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= G_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    if (neg) begin
      sat_mag = (acc > sce_pkg::PROD_W'(sce_pkg::SAT_NEG)) ?
                sce_pkg::SAMPLE_W'(sce_pkg::SAT_NEG) : acc[sce_pkg::SAMPLE_W-1:0];
    end else begin
      sat_mag = (acc > sce_pkg::PROD_W'(sce_pkg::SAT_POS)) ?
                sce_pkg::SAMPLE_W'(sce_pkg::SAT_POS) : acc[sce_pkg::SAMPLE_W-1:0];
    end
  end

  assign mag    = sat_mag;
  assign gained = neg ? $signed(sce_pkg::SAMPLE_W'(~sat_mag + 1'b1)) : $signed(sat_mag);

endmodule

// ===== design/sce_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_track
// Capture state, store addressing and the frame-end speech decision.
// ----------------------------------------------------------------------------
module sce_track (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [1:0]                   op,
  input  logic [sce_pkg::SAMPLE_W-1:0] mag,
  input  sce_pkg::cfg_t                cfg,
  output logic                         done,
  output sce_pkg::track_out_t          result
);

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_ADD    = 3'b010,
    T_DECIDE = 3'b100
  } tstate_t;

  tstate_t                       state;
  sce_pkg::rec_t                 status;
  sce_pkg::cause_t               reason;
  logic [sce_pkg::CNT_W-1:0]     wi;
  logic [sce_pkg::FRAME_W-1:0]   fpos;
  logic [sce_pkg::FRAME_W-1:0]   fstored;
  logic [sce_pkg::SAMPLE_W-1:0]  peak;
  logic                          seen;
  logic [sce_pkg::CNT_W-1:0]     speech_cnt;
  logic [sce_pkg::CNT_W-1:0]     silence_cnt;
  logic [sce_pkg::CNT_W-1:0]     lead_cnt;
  logic                          en;
  logic [sce_pkg::ADDR_W-1:0]    addr;
  logic                          br_lead;
  logic                          br_trail;
  logic                          short_frame;

  logic [sce_pkg::FRAME_W-1:0]   fpos_inc;
  logic [sce_pkg::CNT_W-1:0]     n_ext;
  logic                          lead_hit;
  logic                          trail_hit;

  assign fpos_inc  = fpos + 1'b1;
  assign n_ext     = {{(sce_pkg::CNT_W-sce_pkg::FRAME_W){1'b0}}, fstored};
  assign lead_hit  = br_lead && (lead_cnt >= cfg.lead_limit);
  assign trail_hit = br_trail && (speech_cnt >= cfg.min_speech) &&
                     (silence_cnt >= cfg.trail_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= T_IDLE;
      done        <= 1'b0;
      status      <= sce_pkg::REC_IDLE;
      reason      <= sce_pkg::CAUSE_NONE;
      wi          <= '0;
      fpos        <= '0;
      fstored     <= '0;
      peak        <= '0;
      seen        <= 1'b0;
      speech_cnt  <= '0;
      silence_cnt <= '0;
      lead_cnt    <= '0;
      en          <= 1'b0;
      addr        <= '0;
      br_lead     <= 1'b0;
      br_trail    <= 1'b0;
      short_frame <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: begin
          if (go) begin
            en   <= 1'b0;
            addr <= '0;
            done <= 1'b1;
            case (op)
              sce_pkg::OP_SAMPLE: begin
                if (status == sce_pkg::REC_ACTIVE) begin
                  if (wi < cfg.cap) begin
                    en      <= 1'b1;
                    addr    <= wi[sce_pkg::ADDR_W-1:0];
                    wi      <= wi + 1'b1;
                    fstored <= fstored + 1'b1;
                    if (mag > peak) begin
                      peak <= mag;
                    end
                  end
                  fpos <= fpos_inc;
                  if (fpos_inc >= cfg.flen) begin
                    done  <= 1'b0;
                    state <= T_ADD;
                  end
                end
              end
              sce_pkg::OP_START: begin
                if (status != sce_pkg::REC_ACTIVE) begin
                  wi          <= '0;
                  fpos        <= '0;
                  fstored     <= '0;
                  peak        <= '0;
                  seen        <= 1'b0;
                  speech_cnt  <= '0;
                  silence_cnt <= '0;
                  lead_cnt    <= '0;
                  reason      <= sce_pkg::CAUSE_NONE;
                  status      <= sce_pkg::REC_ACTIVE;
                end
              end
              sce_pkg::OP_ABORT: begin
                if (status == sce_pkg::REC_ACTIVE) begin
                  fpos        <= '0;
                  fstored     <= '0;
                  peak        <= '0;
                  seen        <= 1'b0;
                  speech_cnt  <= '0;
                  silence_cnt <= '0;
                  lead_cnt    <= '0;
                  wi          <= '0;
                  status      <= sce_pkg::REC_ABORTED;
                  reason      <= sce_pkg::CAUSE_ABORT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        T_ADD: begin
          fpos        <= '0;
          fstored     <= '0;
          peak        <= '0;
          br_lead     <= 1'b0;
          br_trail    <= 1'b0;
          short_frame <= fstored < cfg.flen;
          if (fstored == '0) begin
            // Nothing stored in the frame: the store was already full.
            seen        <= 1'b0;
            speech_cnt  <= '0;
            silence_cnt <= '0;
            lead_cnt    <= '0;
            if (wi != '0) begin
              status <= sce_pkg::REC_COMPLETED;
              reason <= sce_pkg::CAUSE_FULL;
            end else begin
              status <= sce_pkg::REC_FAILED;
              reason <= sce_pkg::CAUSE_EMPTY;
            end
            done  <= 1'b1;
            state <= T_IDLE;
          end else begin
            if (!seen) begin
              if (peak >= cfg.level) begin
                seen        <= 1'b1;
                speech_cnt  <= speech_cnt + n_ext;
                silence_cnt <= '0;
              end else begin
                lead_cnt <= lead_cnt + n_ext;
                br_lead  <= 1'b1;
              end
            end else begin
              speech_cnt <= speech_cnt + n_ext;
              if (peak < cfg.level) begin
                silence_cnt <= silence_cnt + n_ext;
              end else begin
                silence_cnt <= '0;
              end
              br_trail <= 1'b1;
            end
            state <= T_DECIDE;
          end
        end
        T_DECIDE: begin
          if (lead_hit || trail_hit || short_frame) begin
            seen        <= 1'b0;
            speech_cnt  <= '0;
            silence_cnt <= '0;
            lead_cnt    <= '0;
          end
          if (lead_hit) begin
            wi     <= '0;
            status <= sce_pkg::REC_ABORTED;
            reason <= sce_pkg::CAUSE_LEAD;
          end else if (trail_hit || short_frame) begin
            if (wi != '0) begin
              status <= sce_pkg::REC_COMPLETED;
              reason <= trail_hit ? sce_pkg::CAUSE_TRAIL : sce_pkg::CAUSE_FULL;
            end else begin
              status <= sce_pkg::REC_FAILED;
              reason <= sce_pkg::CAUSE_EMPTY;
            end
          end
          done  <= 1'b1;
          state <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign result.store_enable  = en;
  assign result.store_address = addr;
  assign result.rec_state     = status;
  assign result.stop_cause    = reason;
  assign result.stored_total  = wi;

endmodule

// ===== design/sce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_checker
// Port-level checks of the speech capture endpointer, bound to the top level.
// ----------------------------------------------------------------------------
module sce_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [sce_pkg::OUT_W-1:0] m_tdata
);

  logic [2:0] rec_state;
  assign rec_state = m_tdata[39:37];

  // No result survives a reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // One beat is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a beat is in progress");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

  // An address is only reported with a store write.
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[16]) |-> (m_tdata[36:17] == '0))
    else $error("store address without store write");

  // A failed or abandoned capture holds no samples.
  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ((rec_state == sce_pkg::REC_FAILED) ||
                  (rec_state == sce_pkg::REC_ABORTED))) |-> (m_tdata[63:43] == '0))
    else $error("non-zero total after failed or aborted capture");

endmodule

bind speech_capture_endpointer sce_checker u_sce_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
